// ===== hdl/psd_pkg.sv =====
package psd_pkg;

   localparam int CMD_W  = 3;
   localparam int PRIO_W = 6;
   localparam int TICK_W = 32;
   localparam int ERR_W  = 2;

   // request commands
   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELAY    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_START    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SW_DONE  = 3'd4;

   // error codes
   localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
   localparam logic [ERR_W-1:0] ERR_START_SLOT = 2'd1;
   localparam logic [ERR_W-1:0] ERR_IDLE_DELAY = 2'd2;
   localparam logic [ERR_W-1:0] ERR_ZERO_DELAY = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic walk_read;
      logic walk_update;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_tick;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hdl/psd_ram.sv =====
module psd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/psd_ctrl.sv =====
module psd_ctrl
   import psd_pkg::*;
#(
   parameter int THREAD_SLOTS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dp_status_type                       status,
   output ctrl_cmd_type                        cmd,
   output logic [$clog2(THREAD_SLOTS+1)-1:0]   walk_cnt
);

   localparam int CW = $clog2(THREAD_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_WALK   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            accept;
   logic            walk_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign walk_last = (cnt_ff == CW'(THREAD_SLOTS));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = status.req_is_tick ? ST_WALK : ST_FINISH;
            end
         end
         ST_WALK: begin
            cnt_in = cnt_ff + CW'(1);
            if (walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // read slot cnt, update slot cnt-1 from the registered read
   assign cmd.capture     = accept;
   assign cmd.walk_read   = (state_ff == ST_WALK) && !walk_last;
   assign cmd.walk_update = (state_ff == ST_WALK) && (cnt_ff != '0);
   assign cmd.finish      = (state_ff == ST_FINISH) && status.out_free;
   assign walk_cnt        = cnt_ff;

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && walk_last |=> (state_ff == ST_FINISH))
      else $error("walk did not end in finish");

   a_tick_walks: assert property (@(posedge clock) disable iff (reset)
      accept && status.req_is_tick |=> (state_ff == ST_WALK) && (cnt_ff == '0))
      else $error("tick did not start a walk at slot zero");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == ST_IDLE))
      else $error("finish did not return to idle");

endmodule

// ===== hdl/psd_datapath.sv =====
module psd_datapath
   import psd_pkg::*;
#(
   parameter int THREAD_SLOTS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ctrl_cmd_type                        cmd,
   output dp_status_type                       status,
   input  logic [$clog2(THREAD_SLOTS+1)-1:0]   walk_cnt,
   input  logic [CMD_W-1:0]                    req_command,
   input  logic [PRIO_W-1:0]                   req_priority_req,
   input  logic [TICK_W-1:0]                   req_ticks,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [PRIO_W-1:0]                   rsp_next_priority,
   output logic                                rsp_switch_request,
   output logic [ERR_W-1:0]                    rsp_error
);

   localparam int CW = $clog2(THREAD_SLOTS + 1);
   localparam int AW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

   // highest set slot, 1-based, 0 when empty
   function automatic logic [PRIO_W-1:0] top_slot(input logic [THREAD_SLOTS-1:0] map);
      logic [PRIO_W-1:0] p;
      p = '0;
      for (int i = 0; i < THREAD_SLOTS; i++) begin
         if (map[i]) begin
            p = PRIO_W'(i + 1);
         end
      end
      return p;
   endfunction

   logic [CMD_W-1:0]          cmd_ff;
   logic [PRIO_W-1:0]         prio_ff;
   logic [TICK_W-1:0]         ticks_ff;

   logic [THREAD_SLOTS-1:0]   ready_ff, ready_in;
   logic [THREAD_SLOTS-1:0]   delayed_ff, delayed_in;
   logic [THREAD_SLOTS:0]     started_ff, started_in;
   logic [PRIO_W-1:0]         cur_ff, cur_in;
   logic                      cur_valid_ff, cur_valid_in;
   logic [PRIO_W-1:0]         chosen_ff, chosen_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PRIO_W-1:0]         rsp_next_ff;
   logic                      rsp_sw_ff;
   logic [ERR_W-1:0]          rsp_err_ff;
   logic                      res_sw;
   logic [ERR_W-1:0]          res_err;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [TICK_W-1:0]         ram_wdata;
   logic [TICK_W-1:0]         ram_rdata;
   logic [AW-1:0]             ram_raddr;

   logic [CW-1:0]             walk_prev;
   logic [AW-1:0]             walk_idx;
   logic [TICK_W-1:0]         walk_dec;
   logic [AW-1:0]             cur_idx;
   logic [AW-1:0]             start_idx;
   logic                      delay_idle;
   logic                      start_bad;
   logic [THREAD_SLOTS-1:0]   ready_del;
   logic [THREAD_SLOTS-1:0]   sched_map;
   logic [PRIO_W-1:0]         sched_top;
   logic                      sched_valid;
   logic                      sched_sw;
   logic                      chosen_valid;

   assign status.req_is_tick = (req_command == CMD_TICK);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_command;
         prio_ff  <= req_priority_req;
         ticks_ff <= req_ticks;
      end
   end

   assign walk_prev = walk_cnt - CW'(1);
   assign walk_idx  = walk_prev[AW-1:0];
   assign ram_raddr = walk_cnt[AW-1:0];
   assign walk_dec  = ram_rdata - TICK_W'(1);

   assign cur_idx    = AW'(cur_ff - PRIO_W'(1));
   assign start_idx  = AW'(prio_ff - PRIO_W'(1));
   assign delay_idle = !cur_valid_ff || (cur_ff == '0) || (cur_ff > PRIO_W'(THREAD_SLOTS));
   assign start_bad  = (prio_ff > PRIO_W'(THREAD_SLOTS)) ? 1'b1 : started_ff[prio_ff[CW-1:0]];

   always_comb begin
      ready_del          = ready_ff;
      ready_del[cur_idx] = 1'b0;
   end

   assign sched_map    = (cmd_ff == CMD_DELAY) ? ready_del : ready_ff;
   assign sched_top    = top_slot(sched_map);
   assign sched_valid  = (sched_top != '0) || started_ff[0];
   assign sched_sw     = !((!sched_valid && !cur_valid_ff) ||
                           (sched_valid && cur_valid_ff && (cur_ff == sched_top)));
   assign chosen_valid = (chosen_ff != '0) || started_ff[0];

   always_comb begin
      ready_in     = ready_ff;
      delayed_in   = delayed_ff;
      started_in   = started_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      chosen_in    = chosen_ff;
      ram_we       = 1'b0;
      ram_waddr    = walk_idx;
      ram_wdata    = walk_dec;
      res_sw       = 1'b0;
      res_err      = ERR_OK;

      // timeout countdown, one slot per cycle
      if (cmd.walk_update && delayed_ff[walk_idx]) begin
         ram_we = 1'b1;
         if (walk_dec == '0) begin
            ready_in[walk_idx]   = 1'b1;
            delayed_in[walk_idx] = 1'b0;
         end
      end

      if (cmd.finish) begin
         unique case (cmd_ff)
            CMD_DELAY: begin
               if (delay_idle) begin
                  res_err = ERR_IDLE_DELAY;
               end else if (ticks_ff == '0) begin
                  res_err = ERR_ZERO_DELAY;
               end else begin
                  ram_we              = 1'b1;
                  ram_waddr           = cur_idx;
                  ram_wdata           = ticks_ff;
                  ready_in            = ready_del;
                  delayed_in[cur_idx] = 1'b1;
                  chosen_in           = sched_top;
                  res_sw              = sched_sw;
               end
            end
            CMD_START: begin
               if (start_bad) begin
                  res_err = ERR_START_SLOT;
               end else begin
                  started_in[prio_ff[CW-1:0]] = 1'b1;
                  if (prio_ff != '0) begin
                     ready_in[start_idx] = 1'b1;
                  end
               end
            end
            CMD_SCHEDULE: begin
               chosen_in = sched_top;
               res_sw    = sched_sw;
            end
            CMD_SW_DONE: begin
               cur_in       = chosen_ff;
               cur_valid_in = chosen_valid;
            end
            default: begin
               // tick work is done by the walk, unused codes do nothing
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= '0;
         delayed_ff   <= '0;
         started_ff   <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         chosen_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ready_ff     <= ready_in;
         delayed_ff   <= delayed_in;
         started_ff   <= started_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         chosen_ff    <= chosen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_next_ff <= top_slot(ready_in);
         rsp_sw_ff   <= res_sw;
         rsp_err_ff  <= res_err;
      end
   end

   psd_ram #(
      .WIDTH (TICK_W),
      .DEPTH (THREAD_SLOTS)
   ) u_timeouts (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.walk_read),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_priority  = rsp_next_ff;
   assign rsp_switch_request = rsp_sw_ff;
   assign rsp_error          = rsp_err_ff;

   a_ready_delayed_apart: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & delayed_ff) == '0)
      else $error("slot both ready and delayed");

   a_waiting_started: assert property (@(posedge clock) disable iff (reset)
      ((ready_ff | delayed_ff) & ~started_ff[THREAD_SLOTS:1]) == '0)
      else $error("ready or delayed slot was never started");

   a_chosen_in_range: assert property (@(posedge clock) disable iff (reset)
      chosen_ff <= PRIO_W'(THREAD_SLOTS))
      else $error("chosen slot out of range");

endmodule

// ===== hdl/priority_scheduler_with_delays_unit.sv =====
// Bitmap priority scheduler with tick delays. Slots 1..THREAD_SLOTS are
// threads (higher number wins), slot 0 is the idle thread. Each request
// carries a command (tick, delay current, start, schedule, switch done) and
// gives exactly one response with the highest ready slot, a switch flag and
// an error code. A tick request walks through the timeout memory before
// its response, reading one timeout and writing back one decremented
// timeout per cycle; every other request goes straight to its response.
// One request is in work at a time; a finished response sits in an output
// register, so a new request is taken while the previous response waits.
// Timeouts need no clearing after reset, since a slot's timeout is written
// before it is ever counted down.
module priority_scheduler_with_delays_unit
   import psd_pkg::*;
#(
   parameter int THREAD_SLOTS = 32
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [PRIO_W-1:0]   req_priority_req,
   input  logic [TICK_W-1:0]   req_ticks,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PRIO_W-1:0]   rsp_next_priority,
   output logic                rsp_switch_request,
   output logic [ERR_W-1:0]    rsp_error
);

   localparam int CW = $clog2(THREAD_SLOTS + 1);

   // command and status between the sequencer and the datapath
   ctrl_cmd_type    cmd;
   dp_status_type   status;
   logic [CW-1:0]   walk_cnt;

   // sequencer: idle, timeout walk, finish
   psd_ctrl #(
      .THREAD_SLOTS (THREAD_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .walk_cnt  (walk_cnt)
   );

   // bitmaps, running thread, timeout memory and response register
   psd_datapath #(
      .THREAD_SLOTS (THREAD_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .walk_cnt           (walk_cnt),
      .req_command        (req_command),
      .req_priority_req   (req_priority_req),
      .req_ticks          (req_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_next_priority  (rsp_next_priority),
      .rsp_switch_request (rsp_switch_request),
      .rsp_error          (rsp_error)
   );

endmodule

// ===== tb/tb_priority_scheduler_with_delays_unit.sv =====
module tb_priority_scheduler_with_delays_unit
   import psd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD = 12;
   localparam int NUM_ITEMS = 1750;
   // no request or response accepted for this long means the block hung
   localparam int IDLE_LIMIT = 2000;
   // extra wait after the drain, for a late extra response
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_SLOT = 32;

   // commands the block ignores
   localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [PRIO_W-1:0] next_priority;
      logic              switch_request;
      logic [ERR_W-1:0]  error;
   } sched_outcome_type;

   // scheduler state mirror plus the queue of responses still owed
   class sched_scoreboard_type;
      bit [31:0]         ready_map;
      bit [31:0]         delayed_map;
      bit [32:0]         started_map;
      bit [31:0]         timeout_mem [32];
      bit [PRIO_W-1:0]   cur_prio;
      bit                cur_valid;
      bit [PRIO_W-1:0]   chosen_prio;
      sched_outcome_type owed_outcomes [$];
      int unsigned       mismatches;

      function bit [PRIO_W-1:0] highest_slot(bit [31:0] map);
         bit [PRIO_W-1:0] p;
         p = '0;
         for (int i = 0; i < 32; i++)
            if (map[i]) p = PRIO_W'(i + 1);
         return p;
      endfunction

      function bit chosen_runs();
         return (chosen_prio != 0) || started_map[0];
      endfunction

      // pick the highest ready slot, tell whether a switch is needed
      function bit pick_next();
         bit cv;
         chosen_prio = highest_slot(ready_map);
         cv = chosen_runs();
         if (!cv && !cur_valid) return 1'b0;
         if (cv && cur_valid && cur_prio == chosen_prio) return 1'b0;
         return 1'b1;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [PRIO_W-1:0] prio,
                                 logic [TICK_W-1:0] ticks);
         sched_outcome_type o;
         bit [4:0]          idx;
         o = '0;
         case (cmd)
            CMD_TICK: begin
               for (int i = 0; i < 32; i++) begin
                  if (delayed_map[i]) begin
                     timeout_mem[i] = timeout_mem[i] - 1;
                     if (timeout_mem[i] == 0) begin
                        ready_map[i] = 1'b1;
                        delayed_map[i] = 1'b0;
                     end
                  end
               end
            end
            CMD_DELAY: begin
               if (!cur_valid || cur_prio == 0 || cur_prio > MAX_SLOT) begin
                  o.error = ERR_IDLE_DELAY;
               end else if (ticks == 0) begin
                  o.error = ERR_ZERO_DELAY;
               end else begin
                  idx = 5'(cur_prio - 1);
                  timeout_mem[idx] = ticks;
                  ready_map[idx] = 1'b0;
                  delayed_map[idx] = 1'b1;
                  o.switch_request = pick_next();
               end
            end
            CMD_START: begin
               if (prio > MAX_SLOT) begin
                  o.error = ERR_START_SLOT;
               end else if (started_map[prio]) begin
                  o.error = ERR_START_SLOT;
               end else begin
                  started_map[prio] = 1'b1;
                  if (prio != 0) ready_map[5'(prio - 1)] = 1'b1;
               end
            end
            CMD_SCHEDULE: begin
               o.switch_request = pick_next();
            end
            CMD_SW_DONE: begin
               cur_valid = chosen_runs();
               cur_prio = chosen_prio;
            end
            default: begin
            end
         endcase
         o.next_priority = highest_slot(ready_map);
         owed_outcomes.push_back(o);
      endfunction

      function void check_response(logic [PRIO_W-1:0] np, logic sw, logic [ERR_W-1:0] err);
         sched_outcome_type exp_o;
         if (owed_outcomes.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response: next %0d switch %0b error %0d", np, sw, err);
            mismatches++;
            return;
         end
         exp_o = owed_outcomes.pop_front();
         if (np !== exp_o.next_priority || sw !== exp_o.switch_request ||
             err !== exp_o.error) begin
            if (mismatches < 10)
               $display({"response mismatch: expected next %0d switch %0b error %0d, ",
                         "got next %0d switch %0b error %0d"},
                        exp_o.next_priority, exp_o.switch_request, exp_o.error,
                        np, sw, err);
            mismatches++;
         end
      endfunction

      function int pending();
         return owed_outcomes.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [CMD_W-1:0]    req_command;
   logic [PRIO_W-1:0]   req_priority_req;
   logic [TICK_W-1:0]   req_ticks;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [PRIO_W-1:0]   rsp_next_priority;
   logic                rsp_switch_request;
   logic [ERR_W-1:0]    rsp_error;

   sched_scoreboard_type sb = new();
   // when set, neither side inserts gaps or stalls
   bit          no_idle;
   int unsigned items_sent;
   int unsigned idle_cycles;

   priority_scheduler_with_delays_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_priority_req   (req_priority_req),
      .req_ticks          (req_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_next_priority  (rsp_next_priority),
      .rsp_switch_request (rsp_switch_request),
      .rsp_error          (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // one request: optional gap, then hold it until the block takes it
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] prio,
                               input logic [TICK_W-1:0] ticks);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_priority_req <= prio;
      req_ticks <= ticks;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
   endtask

   // delay length for a well-formed delay: mostly short, sometimes zero
   function automatic logic [TICK_W-1:0] short_delay();
      if ($urandom_range(0, 7) == 0) return '0;
      return TICK_W'($urandom_range(1, 6));
   endfunction

   task automatic req_noise(input logic [CMD_W-1:0] cmd);
      logic [TICK_W-1:0] ticks;
      ticks = $urandom;
      if (cmd == CMD_DELAY && $urandom_range(0, 3) != 0)
         ticks = short_delay();
      send_request(cmd, 6'($urandom_range(0, 63)), ticks);
   endtask

   // response side: random stall before each response, then take it
   initial begin : rsp_side
      int unsigned hold;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 5);
         if (hold != 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      end
   end

   // monitor: note accepted requests, check accepted responses, watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_response(rsp_next_priority, rsp_switch_request, rsp_error);
         if (req_valid === 1'b1 && req_stall === 1'b0)
            sb.note_request(req_command, req_priority_req, req_ticks);
         if ((rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
             (req_valid === 1'b1 && req_stall === 1'b0))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned kind;
      int unsigned burst;
      int unsigned next_mode_flip;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_TICK;
      req_priority_req = '0;
      req_ticks = '0;
      no_idle = 1'b0;
      items_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: nothing running yet
      send_request(CMD_DELAY, 6'd0, 32'd5);          // delay with no thread
      send_request(CMD_SW_DONE, 6'd0, 32'd0);        // switch to "no thread"
      send_request(CMD_SCHEDULE, 6'd0, 32'd0);       // no thread on both sides
      send_request(CMD_START, 6'd33, 32'd0);         // slot out of range
      send_request(CMD_START, 6'd63, 32'hFFFF_FFFF);
      // idle thread
      send_request(CMD_START, 6'd0, 32'd0);          // idle started, nothing ready
      send_request(CMD_START, 6'd0, 32'd0);          // idle already taken
      send_request(CMD_SCHEDULE, 6'd0, 32'd0);       // idle chosen, switch needed
      send_request(CMD_SW_DONE, 6'd0, 32'd0);
      send_request(CMD_DELAY, 6'd0, 32'd7);          // delay from idle
      // real threads at the extremes
      send_request(CMD_START, 6'd32, 32'd0);
      send_request(CMD_START, 6'd1, 32'd0);
      send_request(CMD_START, 6'd32, 32'd0);         // slot taken
      send_request(CMD_SCHEDULE, 6'd63, 32'd0);
      send_request(CMD_SW_DONE, 6'd0, 32'd0);
      send_request(CMD_DELAY, 6'd0, 32'd0);          // zero delay
      send_request(CMD_DELAY, 6'd0, 32'd1);          // top thread parks, low one picked
      send_request(CMD_TICK, 6'd0, 32'd0);           // top thread back
      send_request(CMD_SCHEDULE, 6'd0, 32'd0);
      send_request(CMD_SW_DONE, 6'd0, 32'd0);
      send_request(CMD_DELAY, 6'd0, 32'd2);
      send_request(CMD_SW_DONE, 6'd0, 32'd0);
      // ignored commands
      send_request(CMD_SPARE_5, 6'd63, 32'hFFFF_FFFF);
      send_request(CMD_SPARE_6, 6'd0, 32'h8000_0000);
      send_request(CMD_SPARE_7, 6'd21, 32'h5555_AAAA);

      // random: mostly kernel-like sequences, some noise
      next_mode_flip = items_sent + 150;
      while (items_sent < NUM_ITEMS) begin
         if (items_sent >= next_mode_flip) begin
            no_idle = ($urandom_range(0, 3) == 0);
            next_mode_flip = items_sent + 150;
         end
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            // schedule then switch
            send_request(CMD_SCHEDULE, 6'($urandom_range(0, 63)), $urandom);
            send_request(CMD_SW_DONE, 6'($urandom_range(0, 63)), $urandom);
         end else if (kind < 45) begin
            // running thread sleeps, usually followed by the switch
            send_request(CMD_DELAY, 6'($urandom_range(0, 63)), short_delay());
            if ($urandom_range(0, 3) != 0)
               send_request(CMD_SW_DONE, 6'($urandom_range(0, 63)), $urandom);
         end else if (kind < 75) begin
            // a few timer ticks
            burst = $urandom_range(1, 4);
            repeat (burst)
               send_request(CMD_TICK, 6'($urandom_range(0, 63)), $urandom);
         end else if (kind < 85) begin
            // thread start, sometimes with a bad slot
            if ($urandom_range(0, 9) < 7)
               send_request(CMD_START, 6'($urandom_range(0, MAX_SLOT)), $urandom);
            else
               send_request(CMD_START, 6'($urandom_range(MAX_SLOT + 1, 63)), $urandom);
         end else begin
            // noise: any command, random fields; a long delay parks a thread for good
            req_noise(CMD_W'($urandom_range(0, 7)));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then allow for a late extra response
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
